// File: hw/rtl/svl_pkg.sv
// Shared widths, codes and cell types of the sorted value list.
package svl_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MATCH_W  = 5;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned ENTRY_W  = 5;
  localparam int unsigned TOTAL_W  = 36;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic   ins;
    logic   del;
    logic   clr;
    value_t value;
  } cell_cmd_t;

  // What a cell shows its neighbours and the control logic
  typedef struct packed {
    value_t value;
    logic   valid;
    logic   lt;
    logic   eq;
  } cell_state_t;

endpackage

// File: hw/rtl/svl_in_if.sv
// Input channel of the sorted value list: operation word.
interface svl_in_if;
  logic                             valid;
  logic                             ready;
  logic [svl_pkg::FUNC_W-1:0]       func;
  logic signed [svl_pkg::VALUE_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

// File: hw/rtl/svl_out_if.sv
// Output channel of the sorted value list: result word.
interface svl_out_if;
  logic                               valid;
  logic                               ready;
  logic [svl_pkg::STATUS_W-1:0]       status;
  logic [svl_pkg::MATCH_W-1:0]        match_count;
  logic [svl_pkg::POS_W-1:0]          first_position;
  logic [svl_pkg::ENTRY_W-1:0]        entry_count;
  logic signed [svl_pkg::TOTAL_W-1:0] total;

  modport source (output valid, status, match_count, first_position, entry_count, total,
                  input ready);
  modport sink   (input valid, status, match_count, first_position, entry_count, total,
                  output ready);
endinterface

// File: hw/rtl/sorted_value_list.sv
// Top level of the sorted value list: a row of compare-and-shift cells with result register.
//
// Keeps up to CAPACITY signed values in ascending order in a row of cells, each
// of which compares its value with the operand and shifts with its neighbours on
// the same clock edge. Every operation (insert, search, delete first match,
// clear) is applied to the row on the edge that accepts its word: a word is
// accepted in every cycle in which the result register is empty or its word is
// being taken, and its result word appears in the next cycle. The cell row
// updates all slots at once, and a single result register holds the result
// word. Reset empties the list at once; no clearing pass is needed.
module sorted_value_list (
  input  logic      clk_i,
  input  logic      rst_ni,
  svl_in_if.sink    in_i,
  svl_out_if.source out_o
);

  svl_pkg::cell_cmd_t   cmd;
  svl_pkg::cell_state_t cell_state [svl_pkg::CAPACITY];
  svl_pkg::cell_state_t prev_state [svl_pkg::CAPACITY];
  svl_pkg::cell_state_t next_state [svl_pkg::CAPACITY];

  logic [svl_pkg::CAPACITY-1:0] lt_bits, le_bits, eq_bits;
  svl_pkg::count_t              cnt_lt, cnt_le;

  svl_pkg::count_t                    held_q, held_d;
  logic signed [svl_pkg::TOTAL_W-1:0] sum_q, sum_d, operand_wide;

  logic                               out_valid_q, out_valid_d;
  svl_pkg::status_e                   status_q, status_d;
  logic [svl_pkg::MATCH_W-1:0]        match_q, match_d;
  logic [svl_pkg::POS_W-1:0]          pos_q, pos_d;
  logic [svl_pkg::ENTRY_W-1:0]        entry_q;
  logic signed [svl_pkg::TOTAL_W-1:0] total_q;

  svl_pkg::func_e op;
  logic           accept, full, empty, found;
  logic           ins_en, del_en, clr_en;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign op         = svl_pkg::func_e'(in_i.func);

  assign full         = (held_q == svl_pkg::CNT_W'(svl_pkg::CAPACITY));
  assign empty        = (held_q == '0);
  assign found        = |eq_bits;
  assign operand_wide = svl_pkg::TOTAL_W'(in_i.value);

  assign cmd.ins   = accept && ins_en;
  assign cmd.del   = accept && del_en;
  assign cmd.clr   = accept && clr_en;
  assign cmd.value = in_i.value;

  // Build the row and wire each cell to its neighbours
  for (genvar g = 0; g < svl_pkg::CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_state[g] = '{value: '0, valid: 1'b1, lt: 1'b1, eq: 1'b0};
    end else begin : g_mid
      assign prev_state[g] = cell_state[g-1];
    end
    if (g == svl_pkg::CAPACITY - 1) begin : g_last
      assign next_state[g] = '0;
    end else begin : g_inner
      assign next_state[g] = cell_state[g+1];
    end

    svl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .prev_i  (prev_state[g]),
      .next_i  (next_state[g]),
      .state_o (cell_state[g])
    );

    assign lt_bits[g] = cell_state[g].lt;
    assign eq_bits[g] = cell_state[g].eq;
    assign le_bits[g] = cell_state[g].lt || cell_state[g].eq;
  end

  svl_count u_count_lt (
    .therm_i (lt_bits),
    .count_o (cnt_lt)
  );

  svl_count u_count_le (
    .therm_i (le_bits),
    .count_o (cnt_le)
  );

  // Decode the operation into cell commands and the result word
  always_comb begin
    ins_en   = 1'b0;
    del_en   = 1'b0;
    clr_en   = 1'b0;
    status_d = svl_pkg::STATUS_OK;
    match_d  = '0;
    pos_d    = '0;
    held_d   = held_q;
    sum_d    = sum_q;
    case (op)
      svl_pkg::FUNC_INSERT: begin
        if (full) begin
          status_d = svl_pkg::STATUS_FULL;
        end else begin
          ins_en = 1'b1;
          held_d = held_q + svl_pkg::CNT_W'(1);
          sum_d  = sum_q + operand_wide;
        end
      end
      svl_pkg::FUNC_SEARCH: begin
        if (empty) begin
          status_d = svl_pkg::STATUS_EMPTY;
        end else if (!found) begin
          status_d = svl_pkg::STATUS_NOT_FOUND;
        end else begin
          match_d = svl_pkg::MATCH_W'(cnt_le - cnt_lt);
          pos_d   = svl_pkg::POS_W'(cnt_lt);
        end
      end
      svl_pkg::FUNC_DELETE: begin
        if (empty) begin
          status_d = svl_pkg::STATUS_EMPTY;
        end else if (!found) begin
          status_d = svl_pkg::STATUS_NOT_FOUND;
        end else begin
          del_en = 1'b1;
          held_d = held_q - svl_pkg::CNT_W'(1);
          sum_d  = sum_q - operand_wide;
        end
      end
      svl_pkg::FUNC_CLEAR: begin
        clr_en = 1'b1;
        held_d = '0;
        sum_d  = '0;
      end
      default: begin
        status_d = svl_pkg::STATUS_OK;
      end
    endcase
  end

  // Keep the result word until it is taken
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
      sum_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        held_q <= held_d;
        sum_q  <= sum_d;
      end
    end
  end

  // Load the result payload on each accepted word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      match_q  <= match_d;
      pos_q    <= pos_d;
      entry_q  <= svl_pkg::ENTRY_W'(held_d);
      total_q  <= sum_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.match_count    = match_q;
  assign out_o.first_position = pos_q;
  assign out_o.entry_count    = entry_q;
  assign out_o.total          = total_q;

endmodule

// File: hw/rtl/svl_cell.sv
// One slot of the sorted row: holds a value, compares it and shifts with its neighbours.
module svl_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  svl_pkg::cell_cmd_t   cmd_i,
  input  svl_pkg::cell_state_t prev_i,
  input  svl_pkg::cell_state_t next_i,
  output svl_pkg::cell_state_t state_o
);

  svl_pkg::value_t value_q, value_d;
  logic            valid_q, valid_d;
  logic            lt;

  // Compare the held value against the broadcast operand
  assign lt = valid_q && (value_q < cmd_i.value);

  assign state_o.value = value_q;
  assign state_o.valid = valid_q;
  assign state_o.lt    = lt;
  assign state_o.eq    = valid_q && (value_q == cmd_i.value);

  // Hold, take the operand, or shift in from a neighbour
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.clr) begin
      valid_d = 1'b0;
    end else if (cmd_i.ins && !lt) begin
      if (prev_i.lt) begin
        value_d = cmd_i.value;
        valid_d = 1'b1;
      end else begin
        value_d = prev_i.value;
        valid_d = prev_i.valid;
      end
    end else if (cmd_i.del && !lt) begin
      value_d = next_i.value;
      valid_d = next_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Slot payload needs no reset: the valid bit guards it
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// File: hw/rtl/svl_count.sv
// Thermometer-to-count encoder over the row of cell flags.
module svl_count (
  input  logic [svl_pkg::CAPACITY-1:0] therm_i,
  output svl_pkg::count_t              count_o
);

  logic [svl_pkg::CAPACITY-1:0] edge_bit;

  // Mark the last set flag of the thermometer
  always_comb begin
    for (int unsigned i = 0; i < svl_pkg::CAPACITY; i++) begin
      if (i == svl_pkg::CAPACITY - 1) begin
        edge_bit[i] = therm_i[i];
      end else begin
        edge_bit[i] = therm_i[i] && !therm_i[i+1];
      end
    end
  end

  // Encode the one-hot edge as a count of set flags
  always_comb begin
    count_o = '0;
    for (int unsigned i = 0; i < svl_pkg::CAPACITY; i++) begin
      if (edge_bit[i]) begin
        count_o = count_o | svl_pkg::CNT_W'(i + 1);
      end
    end
  end

endmodule

// File: hw/rtl/svl_check.sv
// Port-level assertions for the sorted value list, bound to its top level.
module svl_check (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [svl_pkg::STATUS_W-1:0]       status_i,
  input logic [svl_pkg::MATCH_W-1:0]        match_count_i,
  input logic [svl_pkg::POS_W-1:0]          first_position_i,
  input logic [svl_pkg::ENTRY_W-1:0]        entry_count_i,
  input logic signed [svl_pkg::TOTAL_W-1:0] total_i
);

  // A stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // Every accepted word yields a result word in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted word produced no result");

  // A full report means the list holds its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == svl_pkg::STATUS_FULL
      |-> entry_count_i == svl_pkg::ENTRY_W'(svl_pkg::CAPACITY))
    else $error("full status with spare slots");

  // An empty report leaves nothing held and no match fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == svl_pkg::STATUS_EMPTY
      |-> entry_count_i == '0 && total_i == '0 && match_count_i == '0
          && first_position_i == '0)
    else $error("empty status with held entries or match fields");

endmodule

bind sorted_value_list svl_check u_svl_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .match_count_i    (out_o.match_count),
  .first_position_i (out_o.first_position),
  .entry_count_i    (out_o.entry_count),
  .total_i          (out_o.total)
);

// File: dv/sorted_value_list_checker.sv
// Checker of the sorted value list: mirrors the list and compares every result word.
module sorted_value_list_checker
  import svl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  svl_in_if    op_i,
  svl_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [MATCH_W-1:0]        match_count;
    logic [POS_W-1:0]          first_position;
    logic [ENTRY_W-1:0]        entry_count;
    logic signed [TOTAL_W-1:0] total;
  } list_result_t;

  // Mirror of the list: sorted slots, number held and running sum
  value_t                    slot_q [CAPACITY];
  int unsigned               held_n;
  logic signed [TOTAL_W-1:0] sum_q;
  list_result_t              awaited_q [$];

  // Apply one operation to the mirror and return the result word it causes
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] op, value_t operand);
    list_result_t r;
    int unsigned  pos;
    int unsigned  hits;
    r        = '0;
    r.status = STATUS_OK;
    case (op)
      FUNC_INSERT: begin
        if (held_n >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          // Place in front of the first value that is not smaller
          pos = 0;
          while (pos < held_n && slot_q[pos] < operand) pos++;
          for (int unsigned i = held_n; i > pos; i--) slot_q[i] = slot_q[i-1];
          slot_q[pos] = operand;
          held_n++;
          sum_q = sum_q + operand;
        end
      end
      FUNC_SEARCH: begin
        if (held_n == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          hits = 0;
          for (int unsigned i = 0; i < held_n; i++) begin
            if (slot_q[i] == operand) begin
              if (hits == 0) r.first_position = POS_W'(i);
              hits++;
            end
          end
          if (hits == 0) r.status = STATUS_NOT_FOUND;
          r.match_count = MATCH_W'(hits);
        end
      end
      FUNC_DELETE: begin
        if (held_n == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          pos = 0;
          while (pos < held_n && slot_q[pos] != operand) pos++;
          if (pos == held_n) begin
            r.status = STATUS_NOT_FOUND;
          end else begin
            // Close the gap left by the first match
            for (int unsigned i = pos; i + 1 < held_n; i++) slot_q[i] = slot_q[i+1];
            held_n--;
            sum_q = sum_q - operand;
          end
        end
      end
      default: begin
        held_n = 0;
        sum_q  = '0;
      end
    endcase
    r.entry_count = ENTRY_W'(held_n);
    r.total       = sum_q;
    return r;
  endfunction

  // Compare taken result words, then predict for the operation word taken
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t seen;
    list_result_t want;
    if (!rst_ni) begin
      held_n = 0;
      sum_q  = '0;
      awaited_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        seen.status         = res_i.status;
        seen.match_count    = res_i.match_count;
        seen.first_position = res_i.first_position;
        seen.entry_count    = res_i.entry_count;
        seen.total          = res_i.total;
        if (awaited_q.size() == 0) begin
          $display("%0t: result word with nothing awaited: expected none, actual %p",
                   $time, seen);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (seen !== want) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time, want, seen);
            fail_count_o++;
          end
        end
      end
      if (op_i.valid === 1'b1 && op_i.ready === 1'b1) begin
        awaited_q.push_back(apply_list_op(op_i.func, op_i.value));
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// File: dv/sorted_value_list_test.sv
// Top of the sorted value list testbench: clock, reset, operation words and verdict.
module sorted_value_list_test;
  import svl_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  svl_in_if  op_ch ();
  svl_out_if res_ch ();

  sorted_value_list i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  sorted_value_list_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .op_i         (op_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  localparam value_t VAL_MAX = 32'sh7fffffff;
  localparam value_t VAL_MIN = 32'sh80000000;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Small values give duplicates and hits, the rest covers every bit
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return value_t'(int'($urandom_range(0, 6)) - 3);
      5:             return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      default:       return value_t'($urandom());
    endcase
  endfunction

  // Bias towards insert or delete so the list both fills and drains
  function automatic func_e pick_op(int unsigned mode);
    int unsigned r;
    int unsigned ins_share;
    r         = $urandom_range(0, 99);
    ins_share = (mode == 0) ? 70 : (mode == 1) ? 40 : 20;
    if (r < 2) return FUNC_CLEAR;
    if (r < 2 + ins_share) return FUNC_INSERT;
    if (r < 22 + ins_share) return FUNC_SEARCH;
    return FUNC_DELETE;
  endfunction

  // Present one operation word, hold it until taken, then maybe idle
  task automatic send_word(func_e op, value_t operand, bit quiet);
    int unsigned gap;
    op_ch.valid <= 1'b1;
    op_ch.func  <= op;
    op_ch.value <= operand;
    forever begin
      @(negedge clk);
      if (op_ch.ready === 1'b1) break;
    end
    @(posedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: bursts of ready with random stalls between
  initial begin
    int unsigned busy;
    int unsigned stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      busy = $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) busy = $urandom_range(30, 80);
      res_ch.ready <= 1'b1;
      repeat (busy) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Operation words and verdict
  initial begin
    int unsigned mode;
    int unsigned burst;
    bit          quiet;
    int unsigned sent;
    rst_n       = 1'b0;
    op_ch.valid = 1'b0;
    op_ch.func  = FUNC_INSERT;
    op_ch.value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, duplicates, misses, clear
    send_word(FUNC_CLEAR,  '0,      1'b0);
    send_word(FUNC_SEARCH, '0,      1'b0);
    send_word(FUNC_DELETE, '0,      1'b0);
    send_word(FUNC_INSERT, VAL_MAX, 1'b0);
    send_word(FUNC_INSERT, VAL_MIN, 1'b0);
    send_word(FUNC_INSERT, '0,      1'b0);
    send_word(FUNC_INSERT, '0,      1'b0);
    send_word(FUNC_INSERT, -32'sd1, 1'b0);
    send_word(FUNC_SEARCH, '0,      1'b0);
    send_word(FUNC_SEARCH, 32'sd5,  1'b0);
    send_word(FUNC_DELETE, 32'sd5,  1'b0);
    send_word(FUNC_SEARCH, VAL_MAX, 1'b0);
    send_word(FUNC_SEARCH, VAL_MIN, 1'b0);
    send_word(FUNC_DELETE, '0,      1'b0);
    send_word(FUNC_DELETE, VAL_MAX, 1'b0);
    send_word(FUNC_DELETE, VAL_MIN, 1'b0);
    send_word(FUNC_INSERT, 32'sd5,  1'b0);
    send_word(FUNC_INSERT, 32'sd5,  1'b0);
    send_word(FUNC_INSERT, 32'sd5,  1'b0);
    send_word(FUNC_SEARCH, 32'sd5,  1'b0);
    send_word(FUNC_CLEAR,  '0,      1'b0);
    send_word(FUNC_SEARCH, 32'sd5,  1'b0);

    // Random bursts, each with its own operation mix and idling
    sent = 0;
    while (sent < 650) begin
      mode  = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(25, 50);
      repeat (burst) begin
        send_word(pick_op(mode), pick_value(), quiet);
        sent++;
      end
    end

    // Drain the results still awaited, then allow for the result register
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/svl_pkg.sv
hw/rtl/svl_in_if.sv
hw/rtl/svl_out_if.sv
hw/rtl/svl_cell.sv
hw/rtl/svl_count.sv
hw/rtl/sorted_value_list.sv
hw/rtl/svl_check.sv
dv/sorted_value_list_checker.sv
dv/sorted_value_list_test.sv
